>>> design/nnue_acc_pkg.sv
// shared constants, field layout and command codes of the nnue accumulator block
// no dependencies; imported by the top level and its port checker

package nnue_acc_pkg;

	// default sizes of the element store and of the partial sum lanes
	localparam int ACC_DEPTH_DEF = 1536;
	localparam int SUM_LANES_DEF = 8;

	// field widths
	localparam int CMD_W      = 2;
	localparam int IDX_W      = 11;
	localparam int DELTA_W    = 16;
	localparam int WEIGHT_W   = 32;
	localparam int CLIP_W     = 15;
	localparam int SQ_W       = 2 * CLIP_W;
	localparam int PSUM_W     = 32;
	localparam int SCORE_W    = 35;

	// clip register value after reset
	localparam logic [CLIP_W-1:0] CLIP_RESET = 15'd255;

	// input tdata layout, lowest bit first
	localparam int IDX_LSB     = 0;
	localparam int DA_LSB      = IDX_LSB + IDX_W;
	localparam int DB_LSB      = DA_LSB + DELTA_W;
	localparam int W_LSB       = DB_LSB + DELTA_W;
	localparam int IN_FIELDS_W = W_LSB + WEIGHT_W;
	localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;

	// output tdata width, score padded to whole bytes
	localparam int OUT_TDATA_W = ((SCORE_W + 7) / 8) * 8;

	// command codes carried in tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_ADD    = 2'd0,
		CMD_SUB    = 2'd1,
		CMD_ADDSUB = 2'd2,
		CMD_EVAL   = 2'd3
	} cmd_t;

endpackage

>>> design/nnue_accumulator_screlu_eval_top.sv
// top level of the nnue accumulator with clipped squared relu output evaluation
// depends on nnue_acc_pkg and nnue_acc_ram

// The block holds ACC_DEPTH signed 16-bit accumulator elements in one synchronous
// ram and SUM_LANES 32-bit partial sums in flip-flops. One item is worked on at a
// time: the element is read when the item is accepted and written back in the next
// cycle; an evaluate item goes through ram read, clamp and square, weight multiply
// and lane add in turn. An item with tlast set then adds up and clears the partial
// sums, one lane per cycle, and then loads the score register; the next item is
// taken while the score waits on the output. After reset the block runs a clearing
// pass over all ACC_DEPTH ram entries before it accepts the first item; configuration
// writes are taken at any time.

module nnue_accumulator_screlu_eval_top #(
	parameter int ACC_DEPTH = nnue_acc_pkg::ACC_DEPTH_DEF,
	parameter int SUM_LANES = nnue_acc_pkg::SUM_LANES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input item stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// elem_index, delta_a, delta_b, out_weight
	input  logic [nnue_acc_pkg::IN_TDATA_W-1:0]  s_tdata,
	// command
	input  logic [nnue_acc_pkg::CMD_W-1:0]       s_tuser,
	input  logic                                 s_tlast,
	// result stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// score
	output logic [nnue_acc_pkg::OUT_TDATA_W-1:0] m_tdata,
	// clip value register write
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [nnue_acc_pkg::CLIP_W-1:0]      cfg_data
);

	import nnue_acc_pkg::*;

	localparam int AW        = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
	localparam int LW        = (SUM_LANES > 1) ? $clog2(SUM_LANES) : 1;
	// lane = index mod SUM_LANES through a reciprocal, exact for 11-bit indexes
	localparam int LaneShift = 24;
	localparam int LaneMul   = (1 << LaneShift) / SUM_LANES + 1;
	localparam int QPW       = IDX_W + LaneShift + 1;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_EXEC  = 7'b0000100,
		ST_MUL   = 7'b0001000,
		ST_ACC   = 7'b0010000,
		ST_SUM   = 7'b0100000,
		ST_OUT   = 7'b1000000
	} state_t;

	state_t                    state_q;
	logic [AW-1:0]             clr_cnt_q;
	logic [LW-1:0]             sum_cnt_q;
	logic [CLIP_W-1:0]         clip_q;
	logic                      m_tvalid_q;
	logic [PSUM_W-1:0]         psum_q [SUM_LANES];

	cmd_t                      cmd_q;
	logic [IDX_W-1:0]          idx_q;
	logic [IDX_W-1:0]          quot_q;
	logic [DELTA_W-1:0]        da_q;
	logic [DELTA_W-1:0]        db_q;
	logic [WEIGHT_W-1:0]       w_q;
	logic                      last_q;
	logic                      in_range_q;
	logic [LW-1:0]             lane_q;
	logic [SQ_W-1:0]           sq_q;
	logic [PSUM_W-1:0]         prod_q;
	logic [SCORE_W-1:0]        total_q;
	logic [SCORE_W-1:0]        score_q;

	logic                      accept;
	logic                      out_load;
	logic [IDX_W-1:0]          idx_in;
	logic [QPW-1:0]            quot_prod;
	logic                      in_range_in;
	logic [IDX_W-1:0]          quot_mul;
	logic [IDX_W-1:0]          rem;
	logic                      ram_we;
	logic [AW-1:0]             ram_waddr;
	logic [DELTA_W-1:0]        ram_wdata;
	logic [DELTA_W-1:0]        ram_rdata;
	logic [DELTA_W-1:0]        upd_val;
	logic [CLIP_W-1:0]         clamped;
	logic [PSUM_W-1:0]         prod_c;

	// handshakes
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = OUT_TDATA_W'(score_q);

	// index decode at accept
	assign idx_in      = s_tdata[IDX_LSB +: IDX_W];
	assign in_range_in = (32'(idx_in) < 32'(ACC_DEPTH));
	assign quot_prod   = QPW'(idx_in) * QPW'(LaneMul);

	// lane from the registered quotient
	assign quot_mul = quot_q * IDX_W'(SUM_LANES);
	assign rem      = idx_q - quot_mul;

	// element update for the three update commands
	always_comb begin
		case (cmd_q)
			CMD_ADD:    upd_val = ram_rdata + da_q;
			CMD_SUB:    upd_val = ram_rdata - da_q;
			CMD_ADDSUB: upd_val = ram_rdata + da_q - db_q;
			default:    upd_val = ram_rdata;
		endcase
	end

	// clamp to zero .. clip value; an element out of range reads as zero
	always_comb begin
		if (!in_range_q || ram_rdata[DELTA_W-1]) begin
			clamped = '0;
		end else if (ram_rdata[CLIP_W-1:0] > clip_q) begin
			clamped = clip_q;
		end else begin
			clamped = ram_rdata[CLIP_W-1:0];
		end
	end

	// low 32 bits of square times weight
	assign prod_c = PSUM_W'(sq_q) * w_q;

	// ram write: clearing pass or read-modify-write
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = '0;
		end else begin
			ram_we    = (state_q == ST_EXEC) && (cmd_q != CMD_EVAL) && in_range_q;
			ram_waddr = AW'(idx_q);
			ram_wdata = upd_val;
		end
	end

	nnue_acc_ram #(
		.WIDTH (DELTA_W),
		.DEPTH (ACC_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (AW'(idx_in)),
		.rdata (ram_rdata)
	);

	// control, configuration and partial sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_cnt_q  <= '0;
			sum_cnt_q  <= '0;
			clip_q     <= CLIP_RESET;
			m_tvalid_q <= 1'b0;
			for (int k = 0; k < SUM_LANES; k++) begin
				psum_q[k] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				clip_q <= cfg_data;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == AW'(ACC_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					sum_cnt_q <= '0;
					if (cmd_q == CMD_EVAL) begin
						state_q <= ST_MUL;
					end else if (last_q) begin
						state_q <= ST_SUM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					psum_q[lane_q] <= psum_q[lane_q] + prod_q;
					state_q        <= last_q ? ST_SUM : ST_IDLE;
				end
				ST_SUM: begin
					// lane zero is consumed, the others move down, zeros fill in
					for (int k = 0; k < SUM_LANES - 1; k++) begin
						psum_q[k] <= psum_q[k + 1];
					end
					psum_q[SUM_LANES - 1] <= '0;
					sum_cnt_q <= sum_cnt_q + 1'b1;
					if (sum_cnt_q == LW'(SUM_LANES - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item fields and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd_t'(s_tuser);
			idx_q      <= idx_in;
			quot_q     <= quot_prod[LaneShift +: IDX_W];
			da_q       <= s_tdata[DA_LSB +: DELTA_W];
			db_q       <= s_tdata[DB_LSB +: DELTA_W];
			w_q        <= s_tdata[W_LSB +: WEIGHT_W];
			last_q     <= s_tlast;
			in_range_q <= in_range_in;
		end
		if (state_q == ST_EXEC) begin
			sq_q    <= SQ_W'(clamped) * SQ_W'(clamped);
			lane_q  <= LW'(rem);
			total_q <= '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_c;
		end
		if (state_q == ST_ACC) begin
			total_q <= '0;
		end
		if (state_q == ST_SUM) begin
			total_q <= total_q + {{(SCORE_W - PSUM_W){psum_q[0][PSUM_W-1]}}, psum_q[0]};
		end
		if (out_load) begin
			score_q <= total_q;
		end
	end

endmodule

>>> design/nnue_acc_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module nnue_acc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1536
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/nnue_acc_chk.sv
// port checker for the nnue accumulator top level, with its bind statement
// depends on nnue_acc_pkg and nnue_accumulator_screlu_eval_top

module nnue_acc_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 s_tlast,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [nnue_acc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// the store is being cleared right after reset, so no item is taken
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !s_tready)
		else $error("item accepted during the clearing pass");

	// one item at a time: the read-modify-write blocks the next item
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while the previous one is still at work");

	// a last item holds off the input while the lanes are added up
	a_sum_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready ##1 !s_tready)
		else $error("item accepted during the partial sum pass");

	// a waiting score stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("score dropped or changed while stalled");

endmodule

bind nnue_accumulator_screlu_eval_top nnue_acc_chk u_nnue_acc_chk (.*);
